// ----- sv/cbc_pkg.sv -----
// ----------------------------------------------------------------------------
// cbc_pkg: shared types and constants for the colour blob centroid core
// Field widths, register indexes, reset values and controller types.
// ----------------------------------------------------------------------------
`default_nettype none

package cbc_pkg;

  localparam int CHAN_W  = 8;   // one colour component
  localparam int CFG_W   = 11;  // widest configuration register
  localparam int RATIO_W = 4;
  localparam int CENT_W  = 10;  // centroid output field
  localparam int CFG_IDX_W = 2;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam logic [CFG_W-1:0]   FRAME_WIDTH_RST  = 11'd320;
  localparam logic [CFG_W-1:0]   FRAME_HEIGHT_RST = 11'd240;
  localparam logic [RATIO_W-1:0] RATIO_RST        = 4'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH     = 2'd0,
    CFG_FRAME_HEIGHT    = 2'd1,
    CFG_DOMINANCE_RATIO = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } ctrl_state_t;

  // commands from the controller to the divider datapath
  typedef struct packed {
    logic load;      // capture frame totals, clear partial remainders
    logic step;      // one quotient bit per lane
    logic load_out;  // move the quotients into the output register
  } div_cmd_t;

endpackage

`default_nettype wire

// ----- sv/cbc_accum.sv -----
// ----------------------------------------------------------------------------
// cbc_accum: pixel datapath
// Holds the configuration, tracks raster position, tests each pixel and
// keeps the running coordinate sums and match count of the current frame.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_accum #(
  parameter int MAX_WIDTH  = cbc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cbc_pkg::MAX_HEIGHT_DEF,
  parameter int CNT_W      = 21,
  parameter int SUM_W      = 31
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [cbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cbc_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                          pix_en,
  input  wire logic [cbc_pkg::CHAN_W-1:0]    red,
  input  wire logic [cbc_pkg::CHAN_W-1:0]    green,
  input  wire logic [cbc_pkg::CHAN_W-1:0]    blue,
  output logic                               frame_end,
  output logic [SUM_W-1:0]                   tot_sum_x,
  output logic [SUM_W-1:0]                   tot_sum_y,
  output logic [CNT_W-1:0]                   tot_count
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WLIM_W = $clog2(MAX_WIDTH + 1);
  localparam int HLIM_W = $clog2(MAX_HEIGHT + 1);
  localparam int WD_W   = (cbc_pkg::CFG_W > WLIM_W) ? cbc_pkg::CFG_W : WLIM_W;
  localparam int HD_W   = (cbc_pkg::CFG_W > HLIM_W) ? cbc_pkg::CFG_W : HLIM_W;
  localparam int PROD_W = cbc_pkg::CHAN_W + cbc_pkg::RATIO_W;

  localparam logic [WD_W-1:0] W_MAX = WD_W'(MAX_WIDTH);
  localparam logic [HD_W-1:0] H_MAX = HD_W'(MAX_HEIGHT);

  logic [cbc_pkg::CFG_W-1:0]   frame_width_r, frame_width_nxt;
  logic [cbc_pkg::CFG_W-1:0]   frame_height_r, frame_height_nxt;
  logic [cbc_pkg::RATIO_W-1:0] ratio_r, ratio_nxt;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [SUM_W-1:0] sum_x_r, sum_x_nxt;
  logic [SUM_W-1:0] sum_y_r, sum_y_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [WD_W-1:0]   w_ext, w_eff, col_inc;
  logic [HD_W-1:0]   h_ext, h_eff, row_inc;
  logic [PROD_W-1:0] prod_r, prod_g, blue_ext;
  logic              match, last_col, last_row;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    ratio_nxt        = ratio_r;
    if (cfg_wr_en) begin
      unique case (cbc_pkg::cfg_idx_t'(cfg_index))
        cbc_pkg::CFG_FRAME_WIDTH:     frame_width_nxt  = cfg_wdata;
        cbc_pkg::CFG_FRAME_HEIGHT:    frame_height_nxt = cfg_wdata;
        cbc_pkg::CFG_DOMINANCE_RATIO: ratio_nxt = cfg_wdata[cbc_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize clamps to the maximum
  always_comb begin
    w_ext = WD_W'(frame_width_r);
    h_ext = HD_W'(frame_height_r);
    if (w_ext == '0)       w_eff = WD_W'(1);
    else if (w_ext > W_MAX) w_eff = W_MAX;
    else                   w_eff = w_ext;
    if (h_ext == '0)       h_eff = HD_W'(1);
    else if (h_ext > H_MAX) h_eff = H_MAX;
    else                   h_eff = h_ext;
    col_inc  = WD_W'(col_r) + WD_W'(1);
    row_inc  = HD_W'(row_r) + HD_W'(1);
    last_col = (col_inc >= w_eff);
    last_row = (row_inc >= h_eff);
  end

  assign frame_end = last_col && last_row;

  always_comb begin
    prod_r   = PROD_W'(ratio_r) * PROD_W'(red);
    prod_g   = PROD_W'(ratio_r) * PROD_W'(green);
    blue_ext = PROD_W'(blue);
    match    = (blue_ext > prod_r) && (blue_ext > prod_g);
  end

  // totals including the current pixel, handed to the divider at frame end
  always_comb begin
    tot_sum_x = sum_x_r;
    tot_sum_y = sum_y_r;
    tot_count = count_r;
    if (match) begin
      tot_sum_x = sum_x_r + SUM_W'(col_r);
      tot_sum_y = sum_y_r + SUM_W'(row_r);
      tot_count = count_r + CNT_W'(1);
    end
  end

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    count_nxt = count_r;
    if (pix_en) begin
      col_nxt = last_col ? '0 : col_r + COL_W'(1);
      if (last_col) begin
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end
      if (frame_end) begin
        sum_x_nxt = '0;
        sum_y_nxt = '0;
        count_nxt = '0;
      end else begin
        sum_x_nxt = tot_sum_x;
        sum_y_nxt = tot_sum_y;
        count_nxt = tot_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= cbc_pkg::FRAME_WIDTH_RST;
      frame_height_r <= cbc_pkg::FRAME_HEIGHT_RST;
      ratio_r        <= cbc_pkg::RATIO_RST;
      col_r          <= '0;
      row_r          <= '0;
      sum_x_r        <= '0;
      sum_y_r        <= '0;
      count_r        <= '0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      ratio_r        <= ratio_nxt;
      col_r          <= col_nxt;
      row_r          <= row_nxt;
      sum_x_r        <= sum_x_nxt;
      sum_y_r        <= sum_y_nxt;
      count_r        <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/cbc_div.sv -----
// ----------------------------------------------------------------------------
// cbc_div: divider datapath and output register
// Two restoring division lanes share one divisor, one quotient bit per
// step; only the low quotient bits that reach the output are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_div #(
  parameter int CNT_W = 21,
  parameter int SUM_W = 31
) (
  input  wire logic                        clk,
  input  wire cbc_pkg::div_cmd_t           cmd,
  input  wire logic [SUM_W-1:0]            tot_sum_x,
  input  wire logic [SUM_W-1:0]            tot_sum_y,
  input  wire logic [CNT_W-1:0]            tot_count,
  output logic                             out_found,
  output logic [cbc_pkg::CENT_W-1:0]       out_cx,
  output logic [cbc_pkg::CENT_W-1:0]       out_cy
);

  localparam int QW = cbc_pkg::CENT_W;

  logic [SUM_W-1:0] dvd_x_r, dvd_y_r;
  logic [CNT_W-1:0] rem_x_r, rem_y_r, divisor_r;
  logic [QW-1:0]    quo_x_r, quo_y_r;
  logic             found_r;

  logic [CNT_W-1:0] rem_x_nxt, rem_y_nxt;
  logic             qbit_x, qbit_y;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  function automatic logic [CNT_W:0] div_step(input logic [CNT_W-1:0] rem,
                                              input logic             dbit,
                                              input logic [CNT_W-1:0] dsor);
    logic [CNT_W:0] shifted;
    logic [CNT_W:0] dsor_ext;
    logic [CNT_W:0] res;
    shifted  = {rem, dbit};
    dsor_ext = {1'b0, dsor};
    if (shifted >= dsor_ext) begin
      res = {1'b1, CNT_W'(shifted - dsor_ext)};
    end else begin
      res = {1'b0, shifted[CNT_W-1:0]};
    end
    return res;
  endfunction

  always_comb begin
    {qbit_x, rem_x_nxt} = div_step(rem_x_r, dvd_x_r[SUM_W-1], divisor_r);
    {qbit_y, rem_y_nxt} = div_step(rem_y_r, dvd_y_r[SUM_W-1], divisor_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvd_x_r   <= tot_sum_x;
      dvd_y_r   <= tot_sum_y;
      divisor_r <= tot_count;
      rem_x_r   <= '0;
      rem_y_r   <= '0;
      quo_x_r   <= '0;
      quo_y_r   <= '0;
      found_r   <= (tot_count != '0);
    end else if (cmd.step) begin
      dvd_x_r <= {dvd_x_r[SUM_W-2:0], 1'b0};
      dvd_y_r <= {dvd_y_r[SUM_W-2:0], 1'b0};
      rem_x_r <= rem_x_nxt;
      rem_y_r <= rem_y_nxt;
      quo_x_r <= {quo_x_r[QW-2:0], qbit_x};
      quo_y_r <= {quo_y_r[QW-2:0], qbit_y};
    end
  end

  // a frame with no match reports zeros
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_found <= found_r;
      out_cx    <= found_r ? quo_x_r : '0;
      out_cy    <= found_r ? quo_y_r : '0;
    end
  end

endmodule

`default_nettype wire

// ----- sv/cbc_ctrl.sv -----
// ----------------------------------------------------------------------------
// cbc_ctrl: controller
// Sequences the frame-end division, paces the pixel input and owns the
// output word's valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_ctrl #(
  parameter int SUM_W = 31
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  input  wire logic               frame_end,
  output logic                    pix_en,
  output cbc_pkg::div_cmd_t       cmd
);

  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

  cbc_pkg::ctrl_state_t state_r, state_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 slot_free;

  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  // the frame's last pixel waits while a previous frame is dividing or awaiting output
  assign in_tready = (state_r == cbc_pkg::ST_IDLE) || !frame_end;
  assign pix_en    = in_tvalid && in_tready;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd          = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      cbc_pkg::ST_IDLE: begin
        if (pix_en && frame_end) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = cbc_pkg::ST_DIV;
        end
      end
      cbc_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = cbc_pkg::ST_DONE;
        end
      end
      cbc_pkg::ST_DONE: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = cbc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cbc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbc_pkg::ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/color_blob_centroid_core.sv -----
// ----------------------------------------------------------------------------
// color_blob_centroid_core: centroid of blue-dominant pixels per frame
// Accumulates matching pixel coordinates and divides at each frame end.
// ----------------------------------------------------------------------------
// Usage
//   in_*   : one RGB pixel per word in raster order, tdata = red, green, blue.
//   out_*  : one word per frame, tuser = found, tdata = centroid x, y.
//   cfg_*  : frame width, frame height and dominance ratio, written while idle.
// Throughput: one pixel per clock, but the frame's last pixel is held off
//   while the previous frame's division is still running or its result
//   is still waiting for the output register to drain.
// Division: once the frame's last pixel is taken, the two-lane restoring
//   divider works through the SUM_W-bit sums (SUM_W = 31 at the default
//   sizes) at one quotient bit per cycle, then loads the output register.
// Reset: synchronous, active low; position, sums and count clear and the
//   registers return to 320 x 240, ratio 5.
// Stall: a waiting result word holds; pixels keep flowing into the next
//   frame, and a finished division waits until the output register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module color_blob_centroid_core #(
  parameter int MAX_WIDTH  = cbc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cbc_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // red [7:0], green [15:8], blue [23:16]
  input  wire logic [23:0]                   in_tdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // centroid_x [9:0], centroid_y [19:10], zero fill [23:20]
  output logic [23:0]                        out_tdata,
  // found [0]
  output logic                               out_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  input  wire logic                          cfg_wr_en,
  input  wire logic [cbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cbc_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int POS_W = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int SUM_W = POS_W + CNT_W;

  localparam int CW = cbc_pkg::CHAN_W;
  localparam int QW = cbc_pkg::CENT_W;

  logic                 frame_end, pix_en;
  cbc_pkg::div_cmd_t    cmd;
  logic [SUM_W-1:0]     tot_sum_x, tot_sum_y;
  logic [CNT_W-1:0]     tot_count;
  logic [QW-1:0]        out_cx, out_cy;
  logic                 out_found;

  cbc_accum #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pix_en    (pix_en),
    .red       (in_tdata[CW-1:0]),
    .green     (in_tdata[2*CW-1:CW]),
    .blue      (in_tdata[3*CW-1:2*CW]),
    .frame_end (frame_end),
    .tot_sum_x (tot_sum_x),
    .tot_sum_y (tot_sum_y),
    .tot_count (tot_count)
  );

  cbc_ctrl #(
    .SUM_W(SUM_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .frame_end (frame_end),
    .pix_en    (pix_en),
    .cmd       (cmd)
  );

  cbc_div #(
    .CNT_W(CNT_W),
    .SUM_W(SUM_W)
  ) u_div (
    .clk       (clk),
    .cmd       (cmd),
    .tot_sum_x (tot_sum_x),
    .tot_sum_y (tot_sum_y),
    .tot_count (tot_count),
    .out_found (out_found),
    .out_cx    (out_cx),
    .out_cy    (out_cy)
  );

  assign out_tdata = {4'b0000, out_cy, out_cx};
  assign out_tuser = out_found;

endmodule

`default_nettype wire

// ----- sv/cbc_checker.sv -----
// ----------------------------------------------------------------------------
// cbc_checker: port-level checks for the colour blob centroid core
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic [23:0]                   out_tdata,
  input wire logic                          out_tuser,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready
);

  // a stalled result word stays and holds its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // reset leaves no result pending
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a frame without a match reports a zero centroid
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 24'd0)
    else $error("non-zero centroid with nothing found");

  // the fill bits above the centroid fields stay zero
  a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:20] == 4'd0)
    else $error("fill bits of result word set");

endmodule

bind color_blob_centroid_core cbc_checker u_cbc_checker (.*);

`default_nettype wire
